// ===== design/lkc_pkg.sv =====
// Package: shared types, token codes, byte constants and the keyword table.
package lkc_pkg;

  localparam int KwCount = 57;
  localparam int KwBytes = 16;

  typedef logic [5:0]         token_code_t;
  typedef logic [KwCount-1:0] kw_mask_t;
  typedef logic [3:0]         byte_pos_t;

  // One input word as held in the input register
  typedef struct packed {
    logic [7:0] ch;
    logic       mode;
    logic       last;
  } lkc_item_t;

  // Number rule flags
  typedef struct packed {
    logic illegal;
    logic dot;
    logic digit;
  } num_flags_t;

  localparam token_code_t CODE_IDENT  = 6'd57;
  localparam token_code_t CODE_NUMBER = 6'd58;
  localparam token_code_t CODE_STRING = 6'd59;
  localparam token_code_t CODE_ERROR  = 6'd60;

  localparam byte_pos_t POS_MAX = 4'd15;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // Keyword table, UTF-8 bytes. Each literal sits right-aligned, zero-padded on the left.
  localparam logic [8*KwBytes-1:0] KW_TEXT [KwCount] = '{
    "PROGRAM", "F\303\226RFATTARE",
    "HEL", "FLYT", "BOK", "BIT", "HALV", "BYTE", "ORD", "VAL", "STRUKTUR",
    "F\303\204LT", "TOM", "TYPDEF",
    "+", "-", "*", "/",
    "(", ")", "<", ">", ",", ";", ":", ".",
    "PEK", "KONSTANT", "STATISK",
    "LIKA", "INTE LIKA", "MINDRE", "ST\303\226RRE", "MINLIK", "ST\303\226LIK",
    "OM", "ANNARS", "MEDAN", "G\303\226R", "F\303\226R", "V\303\204XEL",
    "FALL", "BRYT", "FORTSATT",
    "OCH", "ELLER", "INTE",
    "\303\205TERV\303\204ND",
    "\303\226KAR", "MINSKAR",
    "\303\226KAR MED", "MINSKAR MED", "MULT MED", "DELAS MED",
    "V\303\204RDE VID", "ADRESS AV", "STORLEK AV"
  };

  // Keyword length in bytes (no keyword holds a zero byte)
  function automatic logic [4:0] kw_len(int k);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < KwBytes; i++) begin
      if (KW_TEXT[k][8*i +: 8] != 8'h00) n = n + 5'd1;
    end
    return n;
  endfunction

  // Multi-word keyword: holds a space
  function automatic logic kw_multi(int k);
    logic m;
    m = 1'b0;
    for (int i = 0; i < KwBytes; i++) begin
      if (KW_TEXT[k][8*i +: 8] == CH_SPACE) m = 1'b1;
    end
    return m;
  endfunction

  // Byte p of keyword k, counted from its first character; zero past the end
  function automatic logic [7:0] kw_byte(int k, byte_pos_t p);
    logic [4:0] len;
    logic [3:0] idx;
    len = kw_len(k);
    idx = 4'(len - 5'd1 - {1'b0, p});
    if ({1'b0, p} < len) return KW_TEXT[k][8*idx +: 8];
    return 8'h00;
  endfunction

endpackage

// ===== design/lkc_if.sv =====
// Interfaces: lexeme byte channel and token code channel.
interface lkc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       mode;
  logic       last;

  modport source (output valid, output ch, output mode, output last, input ready);
  modport sink   (input valid, input ch, input mode, input last, output ready);
endinterface

interface lkc_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] token_code;

  modport source (output valid, output token_code, input ready);
  modport sink   (input valid, input token_code, output ready);
endinterface

// ===== design/lexeme_keyword_classifier.sv =====
// Lexeme keyword classifier: turns a byte stream of lexemes into token codes.
//
// in_chan carries one lexeme byte per word (ch, mode, last); mode is taken
// from the first byte of a lexeme, last marks its final byte. out_chan gives
// one token_code per lexeme: 0..56 keyword index, 57 identifier, 58 number,
// 59 string literal, 60 error (pair-mode miss).
// One byte is taken per clock while out_chan takes its codes. Each byte passes
// an input register, then the classifier core updates the lexeme state
// (57 parallel byte compares against the keyword table), and the code of a
// last byte is written to the output register, from which it is valid on
// out_chan until it is taken.
// When out_chan stalls with a code waiting, the core stops processing bytes;
// the input register takes one more word if it is empty, and in_chan.ready
// then stays low until the code is taken.
// Reset (rst_n low, synchronous) empties both registers and returns the
// lexeme state to its start: all keywords candidate, position zero.
module lexeme_keyword_classifier #(
  parameter int MAX_KEYWORD_BYTES = 11
) (
  input  logic      clk,
  input  logic      rst_n,
  lkc_in_if.sink    in_chan,
  lkc_out_if.source out_chan
);
  import lkc_pkg::*;

  lkc_item_t   core_item;
  logic        core_fire;
  logic        can_load;
  logic        res_valid;
  token_code_t res_code;

  lkc_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .advance (can_load),
    .item    (core_item),
    .fire    (core_fire)
  );

  lkc_core #(
    .MAX_KEYWORD_BYTES (MAX_KEYWORD_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (core_item),
    .fire      (core_fire),
    .res_valid (res_valid),
    .res_code  (res_code)
  );

  lkc_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_chan  (out_chan),
    .res_valid (res_valid),
    .res_code  (res_code),
    .can_load  (can_load)
  );

  // A new code appears only after the core processed a last byte
  a_code_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(core_fire && core_item.last))
    else $error("token code without a last byte");

endmodule

// ===== design/lkc_in_stage.sv =====
// Input register: holds one lexeme byte for the classifier core.
module lkc_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  lkc_in_if.sink            in_chan,
  input  logic              advance,
  output lkc_pkg::lkc_item_t item,
  output logic              fire
);
  import lkc_pkg::*;

  logic      valid_r, valid_nxt;
  lkc_item_t item_r;
  logic      in_fire;

  // Register can take a word when empty or when its word moves on this cycle
  assign in_chan.ready = !valid_r || advance;
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign fire          = valid_r && advance;
  assign item          = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_fire) valid_nxt = 1'b1;
    else if (fire) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= '{ch: in_chan.ch, mode: in_chan.mode, last: in_chan.last};
    end
  end

endmodule

// ===== design/lkc_core.sv =====
// Classifier core: per-lexeme state, keyword match and token code selection.
module lkc_core #(
  parameter int MAX_KEYWORD_BYTES = 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lkc_pkg::lkc_item_t   item,
  input  logic                 fire,
  output logic                 res_valid,
  output lkc_pkg::token_code_t res_code
);
  import lkc_pkg::*;

  kw_mask_t   mask_r, mask_nxt;
  byte_pos_t  pos_r, pos_nxt;
  logic       mode_r, mode_nxt;
  logic       quote_r, quote_nxt;
  logic       bad_r, bad_nxt;
  num_flags_t nf_r, nf_nxt;

  kw_mask_t    hit;
  kw_mask_t    word_hit;
  logic        first;
  logic        pos_ok;
  logic        mode_eff;
  logic        quote_eff;
  logic        bad_eff;
  logic        is_digit;
  logic        kw_found;
  token_code_t kw_idx;

  assign first    = (pos_r == '0);
  assign pos_ok   = int'(pos_r) < MAX_KEYWORD_BYTES;
  assign is_digit = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);

  // Mode and opening quote come from the first byte
  assign mode_eff  = first ? item.mode : mode_r;
  assign quote_eff = first ? (item.ch == CH_QUOTE) : quote_r;

  // Inner bytes that break a string literal
  always_comb begin
    bad_eff = bad_r;
    if (!first && !item.last &&
        (item.ch == CH_QUOTE || item.ch == CH_LF || item.ch == CH_CR)) bad_eff = 1'b1;
  end

  // Number rule flags
  always_comb begin
    nf_nxt = nf_r;
    if (is_digit) begin
      nf_nxt.digit = 1'b1;
    end else if (item.ch == CH_DOT) begin
      if (nf_r.dot) nf_nxt.illegal = 1'b1;
      nf_nxt.dot = 1'b1;
    end else begin
      nf_nxt.illegal = 1'b1;
    end
  end

  // Per-keyword byte compare at the current position, and full-length match
  always_comb begin
    kw_idx = '0;
    for (int k = 0; k < KwCount; k++) begin
      hit[k] = mask_r[k] && pos_ok && ({1'b0, pos_r} < kw_len(k)) &&
               (kw_byte(k, pos_r) == item.ch);
      word_hit[k] = hit[k] && (kw_len(k) == ({1'b0, pos_r} + 5'd1)) &&
                    (kw_multi(k) == mode_eff);
      if (word_hit[k]) kw_idx = kw_idx | 6'(k);
    end
  end
  // Keywords are distinct, so at most one full match remains
  assign kw_found = |word_hit;

  // Token code on the last byte
  always_comb begin
    if (!mode_eff && !first && quote_eff && item.ch == CH_QUOTE && !bad_r) begin
      res_code = CODE_STRING;
    end else if (!mode_eff && !nf_nxt.illegal && nf_nxt.digit) begin
      res_code = CODE_NUMBER;
    end else if (kw_found) begin
      res_code = kw_idx;
    end else begin
      res_code = mode_eff ? CODE_ERROR : CODE_IDENT;
    end
  end
  assign res_valid = fire && item.last;

  // Next state: advance on a byte, back to reset after the last one
  always_comb begin
    mask_nxt  = mask_r;
    pos_nxt   = pos_r;
    mode_nxt  = mode_r;
    quote_nxt = quote_r;
    bad_nxt   = bad_r;
    if (fire) begin
      if (item.last) begin
        mask_nxt  = '1;
        pos_nxt   = '0;
        mode_nxt  = 1'b0;
        quote_nxt = 1'b0;
        bad_nxt   = 1'b0;
      end else begin
        mask_nxt  = hit;
        pos_nxt   = (pos_r == POS_MAX) ? POS_MAX : pos_r + 4'd1;
        mode_nxt  = mode_eff;
        quote_nxt = quote_eff;
        bad_nxt   = bad_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= '1;
      pos_r   <= '0;
      mode_r  <= 1'b0;
      quote_r <= 1'b0;
      bad_r   <= 1'b0;
      nf_r    <= '0;
    end else begin
      mask_r  <= mask_nxt;
      pos_r   <= pos_nxt;
      mode_r  <= mode_nxt;
      quote_r <= quote_nxt;
      bad_r   <= bad_nxt;
      if (fire) nf_r <= item.last ? num_flags_t'('0) : nf_nxt;
    end
  end

  // State is back at reset values after a lexeme ends
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.last |=> pos_r == '0 && mask_r == '1 && nf_r == '0 && !bad_r)
    else $error("lexeme state not cleared after last byte");

  // State holds while no byte is processed
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(pos_r) && $stable(mask_r) && $stable(nf_r))
    else $error("lexeme state changed without a byte");

  // Result codes stay within the defined range
  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> res_code <= CODE_ERROR)
    else $error("token code out of range");

endmodule

// ===== design/lkc_out_stage.sv =====
// Output register: holds one token code until the receiver takes it.
module lkc_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  lkc_out_if.source            out_chan,
  input  logic                 res_valid,
  input  lkc_pkg::token_code_t res_code,
  output logic                 can_load
);
  import lkc_pkg::*;

  logic        valid_r;
  token_code_t code_r;

  assign can_load            = !valid_r || out_chan.ready;
  assign out_chan.valid      = valid_r;
  assign out_chan.token_code = code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && res_valid) begin
      code_r <= res_code;
    end
  end

endmodule
